// File: rtl/core/vat_heat_hold_cool_sequencer_defines.svh
// Assertion macros used by the vat sequencer RTL.
`ifndef VAT_HEAT_HOLD_COOL_SEQUENCER_DEFINES_SVH
`define VAT_HEAT_HOLD_COOL_SEQUENCER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define VHHC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define VHHC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/vhhc_pkg.sv
package vhhc_pkg;

	localparam int TEMP_W       = 12;
	localparam int DEG_W        = 7;
	localparam int TOL_W        = 8;
	localparam int HOLD_MIN_W   = 10;
	localparam int PHASE_W      = 3;
	localparam int FAULT_W      = 2;
	localparam int REG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 10;
	// Thresholds are compared one bit wider than the sample so nothing wraps.
	localparam int CMP_W        = TEMP_W + 1;

	localparam int HOLD_MIN_MAX = (1 << HOLD_MIN_W) - 1;
	localparam int DEF_TICKS_PER_MINUTE = 120;

	localparam logic [DEG_W-1:0]      TARGET_RST   = 7'd63;
	localparam int                    HOLD_MIN_RST = 30;
	localparam logic [TOL_W-1:0]      TOL_RST      = 8'd4;
	localparam logic [DEG_W-1:0]      COOL_RST     = 7'd30;

	localparam logic [REG_IDX_W-1:0]  REG_TARGET_TEMP  = 2'd0;
	localparam logic [REG_IDX_W-1:0]  REG_HOLD_MINUTES = 2'd1;
	localparam logic [REG_IDX_W-1:0]  REG_TOLERANCE    = 2'd2;
	localparam logic [REG_IDX_W-1:0]  REG_COOL_TEMP    = 2'd3;

	localparam logic [PHASE_W-1:0]    PH_IDLE = 3'd0;
	localparam logic [PHASE_W-1:0]    PH_HEAT = 3'd1;
	localparam logic [PHASE_W-1:0]    PH_HOLD = 3'd2;
	localparam logic [PHASE_W-1:0]    PH_COOL = 3'd3;
	localparam logic [PHASE_W-1:0]    PH_DONE = 3'd4;

	localparam logic [FAULT_W-1:0]    FLT_NONE      = 2'd0;
	localparam logic [FAULT_W-1:0]    FLT_MILK_LOW  = 2'd1;
	localparam logic [FAULT_W-1:0]    FLT_WATER_LOW = 2'd2;
	localparam logic [FAULT_W-1:0]    FLT_STOPPED   = 2'd3;

	typedef struct packed {
		logic                     start_cmd;
		logic                     stop_pressed;
		logic signed [TEMP_W-1:0] temp_sample;
		logic                     milk_high;
		logic                     water_high;
	} item_t;

	typedef struct packed {
		logic                     heater_on;
		logic                     pump_on;
		logic                     valves_open;
		logic [PHASE_W-1:0]       phase;
		logic [FAULT_W-1:0]       fault;
	} res_t;

	typedef struct packed {
		logic [DEG_W-1:0]         target_temp;
		logic [TOL_W-1:0]         tolerance;
		logic [DEG_W-1:0]         cool_temp;
	} cfg_t;

endpackage

// File: rtl/core/vhhc_cfg.sv
module vhhc_cfg #(
	parameter int TICKS_PER_MINUTE = vhhc_pkg::DEF_TICKS_PER_MINUTE,
	parameter int CNT_W            = 17
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [vhhc_pkg::REG_IDX_W-1:0]   wr_index,
	input  logic [vhhc_pkg::CFG_DATA_W-1:0]  wr_data,
	output vhhc_pkg::cfg_t                   cfg,
	output logic [CNT_W-1:0]                 hold_limit
);
	import vhhc_pkg::*;

	localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(HOLD_MIN_RST * TICKS_PER_MINUTE);

	cfg_t             cfg_q;
	logic [CNT_W-1:0] limit_q;

	// Keep the hold length in ticks so the sequencer never multiplies.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_temp <= TARGET_RST;
			cfg_q.tolerance   <= TOL_RST;
			cfg_q.cool_temp   <= COOL_RST;
			limit_q           <= LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_TARGET_TEMP: begin
					cfg_q.target_temp <= wr_data[DEG_W-1:0];
				end
				REG_HOLD_MINUTES: begin
					limit_q <= CNT_W'(32'(wr_data[HOLD_MIN_W-1:0]) * 32'(TICKS_PER_MINUTE));
				end
				REG_TOLERANCE: begin
					cfg_q.tolerance <= wr_data[TOL_W-1:0];
				end
				REG_COOL_TEMP: begin
					cfg_q.cool_temp <= wr_data[DEG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg        = cfg_q;
	assign hold_limit = limit_q;

endmodule

// File: rtl/core/vhhc_seq.sv
module vhhc_seq #(
	parameter int CNT_W = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  vhhc_pkg::item_t   item,
	input  vhhc_pkg::cfg_t    cfg,
	input  logic [CNT_W-1:0]  hold_limit,
	output vhhc_pkg::res_t    res
);
	import vhhc_pkg::*;

	`include "vat_heat_hold_cool_sequencer_defines.svh"

	typedef enum logic [PHASE_W-1:0] {
		IDLE = PH_IDLE,
		HEAT = PH_HEAT,
		HOLD = PH_HOLD,
		COOL = PH_COOL,
		DONE = PH_DONE
	} state_t;

	state_t                   state_q, state_d;
	logic                     heater_q, heater_d;
	logic [CNT_W-1:0]         cnt_q, cnt_d;
	logic                     pump, valves;
	logic [FAULT_W-1:0]       fault;

	logic signed [CMP_W-1:0]  temp, t16, c16, tol, band_lo, band_hi;

	assign temp    = CMP_W'(item.temp_sample);
	assign t16     = $signed({2'b00, cfg.target_temp, 4'b0000});
	assign c16     = $signed({2'b00, cfg.cool_temp, 4'b0000});
	assign tol     = $signed({5'b00000, cfg.tolerance});
	assign band_lo = t16 - tol;
	assign band_hi = t16 + tol;

	always_comb begin
		state_d  = state_q;
		heater_d = heater_q;
		cnt_d    = cnt_q;
		pump     = 1'b0;
		valves   = 1'b0;
		fault    = FLT_NONE;
		if (item.stop_pressed) begin
			state_d  = IDLE;
			heater_d = 1'b0;
			cnt_d    = '0;
			fault    = FLT_STOPPED;
		end else begin
			case (state_q)
				HEAT: begin
					if (temp < t16) begin
						heater_d = 1'b1;
					end else begin
						heater_d = 1'b0;
						cnt_d    = '0;
						state_d  = HOLD;
					end
				end
				HOLD: begin
					if (cnt_q < hold_limit) begin
						// Inside the band the heater keeps its last setting.
						if (temp < band_lo) begin
							heater_d = 1'b1;
						end else if (temp > band_hi) begin
							heater_d = 1'b0;
						end
						cnt_d = cnt_q + CNT_W'(1);
					end else begin
						heater_d = 1'b0;
						state_d  = COOL;
						valves   = 1'b1;
					end
				end
				COOL: begin
					heater_d = 1'b0;
					if (temp > c16) begin
						pump   = 1'b1;
						valves = 1'b1;
					end else begin
						state_d = DONE;
					end
				end
				default: begin
					heater_d = 1'b0;
					if (state_q != DONE) begin
						state_d = IDLE;
					end
					if (item.start_cmd) begin
						if (!item.milk_high) begin
							fault = FLT_MILK_LOW;
						end else if (!item.water_high) begin
							fault = FLT_WATER_LOW;
						end else begin
							state_d = HEAT;
							cnt_d   = '0;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			heater_q <= 1'b0;
			cnt_q    <= '0;
		end else if (adv) begin
			state_q  <= state_d;
			heater_q <= heater_d;
			cnt_q    <= cnt_d;
		end
	end

	assign res.heater_on   = heater_d;
	assign res.pump_on     = pump;
	assign res.valves_open = valves;
	assign res.phase       = state_d;
	assign res.fault       = fault;

	`VHHC_ASSERT_NXT(a_stop_clears, clk, arst_n, adv && item.stop_pressed,
		state_q == IDLE && cnt_q == '0 && !heater_q, "stop did not return to idle")
	`VHHC_ASSERT_IMP(a_heater_off_idle, clk, arst_n,
		state_q == IDLE || state_q == COOL || state_q == DONE,
		!heater_q, "heater on outside heating and holding")
	`VHHC_ASSERT_NXT(a_heat_to_hold, clk, arst_n,
		adv && !item.stop_pressed && state_q == HEAT && !(temp < t16),
		state_q == HOLD && cnt_q == '0 && !heater_q, "heat exit did not start holding")

endmodule

// File: rtl/core/vat_heat_hold_cool_sequencer.sv
// Vat heat / hold / cool sequencer.
// Input channel (in_valid / in_stall): one word per sample tick with the start
// command, stop button, signed temperature in 1/16 degree and the two level flags.
// Output channel (out_valid / out_stall): one word per input word with heater,
// pump and valve drives, the phase and the fault code of that tick.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): registers 0 target
// temperature, 1 hold minutes, 2 tolerance, 3 cooling temperature; cfg_ready is
// always high. Write only while no word is in flight.
// A word taken into the input register goes on to the result register and then
// shows on the outputs. Throughput is one word per cycle while out_stall is low;
// the phase, heater and hold counter update between the two registers on advance.
// Reset clears the phase to idle, the heater and hold counter, both valids, and
// loads the register defaults (63, 30, 4, 30).
// When out_stall is high a valid result holds; the input register still takes a word
// if it is empty, and in_stall rises once both stages are full.
module vat_heat_hold_cool_sequencer #(
	parameter int TICKS_PER_MINUTE = vhhc_pkg::DEF_TICKS_PER_MINUTE
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   start_cmd,
	input  logic                                   stop_pressed,
	input  logic signed [vhhc_pkg::TEMP_W-1:0]     temp_sample,
	input  logic                                   milk_high,
	input  logic                                   water_high,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   heater_on,
	output logic                                   pump_on,
	output logic                                   valves_open,
	output logic [vhhc_pkg::PHASE_W-1:0]           phase,
	output logic [vhhc_pkg::FAULT_W-1:0]           fault,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [vhhc_pkg::REG_IDX_W-1:0]         cfg_index,
	input  logic [vhhc_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import vhhc_pkg::*;

	localparam int CNT_W = $clog2(HOLD_MIN_MAX * TICKS_PER_MINUTE + 1);

	logic             valid_s1;
	item_t            item_s1;
	logic             out_valid_q;
	res_t             res_q;
	res_t             res;
	cfg_t             cfg;
	logic [CNT_W-1:0] hold_limit;
	logic             adv;

	assign cfg_ready = 1'b1;

	// Advance the input word when the result register is free or draining.
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.start_cmd    <= start_cmd;
			item_s1.stop_pressed <= stop_pressed;
			item_s1.temp_sample  <= temp_sample;
			item_s1.milk_high    <= milk_high;
			item_s1.water_high   <= water_high;
		end
		if (adv) begin
			res_q <= res;
		end
	end

	vhhc_cfg #(
		.TICKS_PER_MINUTE (TICKS_PER_MINUTE),
		.CNT_W            (CNT_W)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg_valid && cfg_ready),
		.wr_index   (cfg_index),
		.wr_data    (cfg_data),
		.cfg        (cfg),
		.hold_limit (hold_limit)
	);

	vhhc_seq #(
		.CNT_W (CNT_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.item       (item_s1),
		.cfg        (cfg),
		.hold_limit (hold_limit),
		.res        (res)
	);

	assign out_valid   = out_valid_q;
	assign heater_on   = res_q.heater_on;
	assign pump_on     = res_q.pump_on;
	assign valves_open = res_q.valves_open;
	assign phase       = res_q.phase;
	assign fault       = res_q.fault;

endmodule
